// File: sv/ssf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssf_pkg - shared types and constants for the speed signal slew filter
// Item payloads, register indexes, reset values and the controller interface.
// ----------------------------------------------------------------------------
package ssf_pkg;

   // Value widths
   localparam int unsigned LEVEL_W    = 16;
   localparam int unsigned SPEED_W    = 17;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned DIV_CNT_W  = 4;

   // Offset carried by the raw speed code
   localparam logic [SPEED_W-1:0] SPEED_OFFSET = 17'd26000;

   // Register reset values
   localparam logic [LEVEL_W-1:0] RISE_DIV_RESET = 16'd8;
   localparam logic [LEVEL_W-1:0] FALL_DIV_RESET = 16'd8;
   localparam logic [LEVEL_W-1:0] CEILING_RESET  = 16'd52000;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_DIVISOR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_DIVISOR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_CEILING = 2'd2;

   // Last iteration index of the bit-serial divider
   localparam logic [DIV_CNT_W-1:0] DIV_LAST_BIT = 4'd15;

   // Input item
   typedef struct packed {
      logic               ignition_on;
      logic               signal_ok;
      logic [LEVEL_W-1:0] raw_speed;
   } req_type;

   // Result item
   typedef struct packed {
      logic signed [SPEED_W-1:0] speed_out;
      logic                      speed_valid;
   } rsp_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_APPLY,
      ST_OUTPUT
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_in;    // capture gap, direction and divisor
      logic div_step;   // one restoring divide iteration
      logic apply;      // commit the stepped and clamped level
      logic load_out;   // load the output register
      logic out_zero;   // result is speed 0, invalid
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;   // output register can take a result this cycle
   } sts_type;

endpackage : ssf_pkg
`default_nettype wire

// File: sv/speed_signal_slew_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// speed_signal_slew_filter - proportional step lag filter on a speed code
// Moves a filtered level toward the raw code by gap / divisor (at least 1),
// clamps it to a ceiling and reports level - 26000; handles ignition off and
// signal faults through an exception mode.
//
//   channel  direction  handshake          payload
//   req      in         valid / stall      ssf_pkg::req_type
//   rsp      out        valid / stall      ssf_pkg::rsp_type
//   csr      in         valid / ready      index (2 bit), wdata (16 bit)
//
// A filtered tick runs the bit-serial restoring divider, one iteration per cycle,
// then the apply and output states before the next accept. Ticks with ignition
// off, a bad signal or in exception mode go straight from idle to output.
// Reset is synchronous; no clearing pass is needed. A result waits in the
// output register while rsp is stalled; the next item is still accepted and
// computed, and only its output load waits for the register to free.
// ----------------------------------------------------------------------------
module speed_signal_slew_filter (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire ssf_pkg::req_type              req_payload,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output ssf_pkg::rsp_type                   rsp_payload,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ssf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ssf_pkg::LEVEL_W-1:0]   csr_wdata
);
   import ssf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencing
   ssf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .ignition_on (req_payload.ignition_on),
      .signal_ok   (req_payload.signal_ok),
      .sts         (sts),
      .cmd         (cmd)
   );

   // Arithmetic and storage
   ssf_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .raw_speed   (req_payload.raw_speed),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule : speed_signal_slew_filter
`default_nettype wire

// File: sv/ssf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssf_ctrl - sequencing controller
// Decides the item's path (zero result or filter step), keeps the exception
// mode and runs the divider iteration count.
// ----------------------------------------------------------------------------
module ssf_ctrl (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire logic           ignition_on,
   input  wire logic           signal_ok,
   input  wire ssf_pkg::sts_type sts,
   output ssf_pkg::cmd_type    cmd
);
   import ssf_pkg::*;

   state_type            state_ff, state_in;
   logic                 exc_ff, exc_in;
   logic                 zero_ff, zero_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   // Next state and control registers
   always_comb begin
      state_in = state_ff;
      exc_in   = exc_ff;
      zero_in  = zero_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!ignition_on) begin
                  zero_in  = 1'b1;
                  state_in = ST_OUTPUT;
               end else if (exc_ff) begin
                  // first good tick leaves exception mode, still no speed
                  exc_in   = !signal_ok;
                  zero_in  = 1'b1;
                  state_in = ST_OUTPUT;
               end else if (!signal_ok) begin
                  exc_in   = 1'b1;
                  zero_in  = 1'b1;
                  state_in = ST_OUTPUT;
               end else begin
                  zero_in  = 1'b0;
                  cnt_in   = DIV_LAST_BIT;
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Command outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.load_in = accept;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
         end
         ST_OUTPUT: begin
            cmd.load_out = sts.out_free;
            cmd.out_zero = zero_ff;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         exc_ff   <= 1'b0;
         zero_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         exc_ff   <= exc_in;
         zero_ff  <= zero_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule : ssf_ctrl
`default_nettype wire

// File: sv/ssf_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssf_dp - filter datapath
// Configuration registers, filtered level, bit-serial restoring divider for
// the step, clamp, and the output register.
// ----------------------------------------------------------------------------
module ssf_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ssf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ssf_pkg::LEVEL_W-1:0]   csr_wdata,
   input  wire logic [ssf_pkg::LEVEL_W-1:0]   raw_speed,
   input  wire ssf_pkg::cmd_type              cmd,
   output ssf_pkg::sts_type                   sts,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output ssf_pkg::rsp_type                   rsp_payload
);
   import ssf_pkg::*;

   logic [LEVEL_W-1:0] rise_div_ff, fall_div_ff, ceiling_ff;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               down_ff, equal_ff;
   logic [LEVEL_W-1:0] div_ff, quo_ff, rem_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_payload_ff, rsp_payload_in;

   logic [LEVEL_W:0]   up_diff, down_diff;
   logic               is_down;
   logic [LEVEL_W-1:0] div_sel;
   logic [LEVEL_W:0]   rem_shift;
   logic [LEVEL_W+1:0] trial;
   logic               fits;
   logic [LEVEL_W-1:0] step, stepped;
   logic [SPEED_W-1:0] speed;

   assign csr_ready = 1'b1;

   // Configuration writes; unused index is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         rise_div_ff <= RISE_DIV_RESET;
         fall_div_ff <= FALL_DIV_RESET;
         ceiling_ff  <= CEILING_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RISE_DIVISOR:  rise_div_ff <= csr_wdata;
            CSR_FALL_DIVISOR:  fall_div_ff <= csr_wdata;
            CSR_LEVEL_CEILING: ceiling_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Gap and direction at item capture; a zero divisor acts as one
   assign up_diff   = {1'b0, raw_speed} - {1'b0, level_ff};
   assign down_diff = {1'b0, level_ff} - {1'b0, raw_speed};
   assign is_down   = up_diff[LEVEL_W];
   assign div_sel   = is_down ? fall_div_ff : rise_div_ff;

   // One restoring divide iteration
   assign rem_shift = {rem_ff, quo_ff[LEVEL_W-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, div_ff};
   assign fits      = !trial[LEVEL_W+1];

   // Step of at least one, then clamp to the ceiling
   assign step    = (quo_ff == '0) ? {{(LEVEL_W-1){1'b0}}, 1'b1} : quo_ff;
   assign stepped = equal_ff ? level_ff :
                    down_ff  ? (level_ff - step) : (level_ff + step);
   always_comb begin
      level_in = level_ff;
      if (cmd.apply) begin
         level_in = (stepped >= ceiling_ff) ? ceiling_ff : stepped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   // Divider registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         down_ff  <= is_down;
         equal_ff <= (up_diff == '0);
         div_ff   <= (div_sel == '0) ? {{(LEVEL_W-1){1'b0}}, 1'b1} : div_sel;
         quo_ff   <= is_down ? down_diff[LEVEL_W-1:0] : up_diff[LEVEL_W-1:0];
         rem_ff   <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[LEVEL_W-2:0], fits};
         rem_ff <= fits ? trial[LEVEL_W-1:0] : rem_shift[LEVEL_W-1:0];
      end
   end

   // Output register
   assign speed        = {1'b0, level_ff} - SPEED_OFFSET;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_payload_in.speed_out   = cmd.out_zero ? '0 : signed'(speed);
      rsp_payload_in.speed_valid = !cmd.out_zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule : ssf_dp
`default_nettype wire
